FILE: rtl/phg_pkg.sv
`default_nettype none
// ============================================================================
// phg_pkg: shared types and constants for pursuit heading guidance
// Holds the transaction payload types, register indexes, reset values, the
// CORDIC arctangent table and the record passed from front end to back end.
// ============================================================================
package phg_pkg;

    // Default number of CORDIC micro-rotations.
    localparam int CORDIC_STEPS_DEF = 16;

    // Datapath widths.
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int ANGLE_W = 16;
    localparam int DIST_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int ACC_W   = 32;
    localparam int VEC_W   = 60;   // CORDIC x/y, difference scaled by 2^24 plus growth
    localparam int SQ_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEER_GAIN     = 2'd0,
        REG_CAPTURE_RADIUS = 2'd1
    } cfg_index_t;

    // Register reset values.
    localparam logic [GAIN_W-1:0] STEER_GAIN_RST     = 16'd6554;
    localparam logic [DIST_W-1:0] CAPTURE_RADIUS_RST = 32'd196608;

    // Largest sum of squares whose root still fits in 32 bits: (2^32-1)^2.
    localparam logic [SQ_W:0] SQ_LIMIT = 65'h0_FFFF_FFFE_0000_0001;

    // Arctangent of 2^-i in units of 2^-32 of a full turn.
    localparam logic [ACC_W-1:0] ATAN_UNITS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Input transaction payload.
    typedef struct packed {
        logic signed [COORD_W-1:0] chaser_x;
        logic signed [COORD_W-1:0] chaser_y;
        logic signed [COORD_W-1:0] goal_x;
        logic signed [COORD_W-1:0] goal_y;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] new_heading;
        logic signed [ANGLE_W-1:0] bearing;
        logic        [DIST_W-1:0]  commanded_speed;
        logic                      intercepted;
    } out_item_t;

    // Configuration register values.
    typedef struct packed {
        logic [GAIN_W-1:0] steer_gain;
        logic [DIST_W-1:0] capture_radius;
    } cfg_t;

    // Work record handed from the front end to the back end.
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic        [SQ_W-1:0]   sum_sq;
        logic                     far;        // distance saturates
        logic                     coincident; // dx = dy = 0
    } work_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage
`default_nettype wire

FILE: rtl/pursuit_heading_guidance.sv
// Flow: the front end forms the differences and squares and queues the work;
// the back end runs 32 square-root steps alongside the CORDIC, then the gain
// and output. It takes a queued item only once the last result is sent; the
// CORDIC (at most 32 steps) finishes within the square-root steps.
// Reset: rst_n clears the kept heading to zero, empties the queue and output,
// and loads steer_gain = 6554 and capture_radius = 196608.
`default_nettype none
// ============================================================================
// pursuit_heading_guidance: pursuit guidance top level
// Holds the configuration registers and connects the input front end, the
// work queue and the CORDIC/square-root back end.
// ============================================================================
module pursuit_heading_guidance #(
    parameter int CORDIC_STEPS = phg_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire phg_pkg::in_item_t                  in_item,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output phg_pkg::out_item_t                      out_item,
    input  wire logic                               cfg_we,
    input  wire logic [phg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [phg_pkg::CFG_DAT_W-1:0]      cfg_data
);

    phg_pkg::cfg_t    cfg_reg;
    phg_pkg::work_t   push_data;
    phg_pkg::work_t   head;
    phg_pkg::q_stat_t stat;
    logic             push;
    logic             pop;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steer_gain     <= phg_pkg::STEER_GAIN_RST;
            cfg_reg.capture_radius <= phg_pkg::CAPTURE_RADIUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                phg_pkg::REG_STEER_GAIN:
                begin
                    cfg_reg.steer_gain <= cfg_data[phg_pkg::GAIN_W-1:0];
                end
                phg_pkg::REG_CAPTURE_RADIUS:
                begin
                    cfg_reg.capture_radius <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    phg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .push      (push),
        .push_data (push_data),
        .stat      (stat)
    );

    phg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    phg_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

FILE: rtl/phg_queue.sv
`default_nettype none
// ============================================================================
// phg_queue: two-entry work queue
// Decouples the front end from the back end so that each stalls on its own.
// ============================================================================
module phg_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire phg_pkg::work_t  push_data,
    input  wire logic            pop,
    output phg_pkg::work_t       head,
    output phg_pkg::q_stat_t     stat
);

    phg_pkg::work_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign do_push    = push && (count_reg != 2'd2);
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/phg_front.sv
`default_nettype none
// ============================================================================
// phg_front: input front end
// Accepts a transaction, forms the coordinate differences, squares them and
// classifies the item (coincident points, saturating distance) before
// queueing it for the back end.
// ============================================================================
module phg_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire phg_pkg::in_item_t   in_item,
    output logic                     push,
    output phg_pkg::work_t           push_data,
    input  wire phg_pkg::q_stat_t    stat
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIFF = 4'b0010,
        F_SQR  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t                     state_reg;
    front_state_t                     state_next;
    phg_pkg::in_item_t                item_reg;
    logic signed [phg_pkg::DIFF_W-1:0] dx_reg;
    logic signed [phg_pkg::DIFF_W-1:0] dy_reg;
    logic [phg_pkg::DIFF_W-1:0]       ax_reg;
    logic [phg_pkg::DIFF_W-1:0]       ay_reg;
    logic [phg_pkg::SQ_W-1:0]         ax2_reg;
    logic [phg_pkg::SQ_W-1:0]         ay2_reg;
    logic signed [phg_pkg::DIFF_W-1:0] dx_w;
    logic signed [phg_pkg::DIFF_W-1:0] dy_w;
    logic [phg_pkg::SQ_W:0]           sum_w;

    // Differences are exact in 33 bits.
    assign dx_w = $signed({item_reg.goal_x[31], item_reg.goal_x})
                - $signed({item_reg.chaser_x[31], item_reg.chaser_x});
    assign dy_w = $signed({item_reg.goal_y[31], item_reg.goal_y})
                - $signed({item_reg.chaser_y[31], item_reg.chaser_y});

    assign sum_w = {1'b0, ax2_reg} + {1'b0, ay2_reg};

    assign in_ready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !stat.full;

    // Work record: saturate when a magnitude or the sum of squares is too big.
    always_comb
    begin
        push_data.dx         = dx_reg;
        push_data.dy         = dy_reg;
        push_data.sum_sq     = sum_w[phg_pkg::SQ_W-1:0];
        push_data.far        = ax_reg[phg_pkg::DIFF_W-1] || ay_reg[phg_pkg::DIFF_W-1]
                             || (sum_w > phg_pkg::SQ_LIMIT);
        push_data.coincident = (dx_reg == '0) && (dy_reg == '0);
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_DIFF;
                end
            end
            F_DIFF:
            begin
                state_next = F_SQR;
            end
            F_SQR:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        if (state_reg == F_DIFF)
        begin
            dx_reg <= dx_w;
            dy_reg <= dy_w;
            ax_reg <= dx_w[phg_pkg::DIFF_W-1] ? 33'(-dx_w) : 33'(dx_w);
            ay_reg <= dy_w[phg_pkg::DIFF_W-1] ? 33'(-dy_w) : 33'(dy_w);
        end
        if (state_reg == F_SQR)
        begin
            ax2_reg <= ax_reg[31:0] * ax_reg[31:0];
            ay2_reg <= ay_reg[31:0] * ay_reg[31:0];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/phg_cordic.sv
`default_nettype none
// ============================================================================
// phg_cordic: iterative vectoring CORDIC
// Turns the difference vector toward the x axis, one micro-rotation per cycle,
// and accumulates the angle in 32-bit binary angle units.
// ============================================================================
module phg_cordic #(
    parameter int CORDIC_STEPS = phg_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [phg_pkg::DIFF_W-1:0]     dx,
    input  wire logic signed [phg_pkg::DIFF_W-1:0]     dy,
    output logic             [phg_pkg::ACC_W-1:0]      angle,
    output logic                                       done
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

    logic signed [phg_pkg::VEC_W-1:0] x_reg;
    logic signed [phg_pkg::VEC_W-1:0] y_reg;
    logic        [phg_pkg::ACC_W-1:0] z_reg;
    logic        [CNT_W-1:0]          cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic signed [phg_pkg::VEC_W-1:0] x_init;
    logic signed [phg_pkg::VEC_W-1:0] y_init;
    logic signed [phg_pkg::VEC_W-1:0] x_sh;
    logic signed [phg_pkg::VEC_W-1:0] y_sh;
    logic        [4:0]                idx;

    // Scale by 2^24 with sign extension.
    assign x_init = $signed({{3{dx[phg_pkg::DIFF_W-1]}}, dx, 24'd0});
    assign y_init = $signed({{3{dy[phg_pkg::DIFF_W-1]}}, dy, 24'd0});

    assign x_sh  = x_reg >>> cnt_reg;
    assign y_sh  = y_reg >>> cnt_reg;
    assign idx   = 5'(cnt_reg);
    assign angle = z_reg;
    assign done  = done_reg;

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Vector and angle; a vector in the left half plane is first turned by pi.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (dx[phg_pkg::DIFF_W-1])
            begin
                x_reg <= -x_init;
                y_reg <= -y_init;
                z_reg <= 32'h8000_0000;
            end
            else
            begin
                x_reg <= x_init;
                y_reg <= y_init;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[phg_pkg::VEC_W-1])
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + phg_pkg::ATAN_UNITS[idx];
            end
            else
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - phg_pkg::ATAN_UNITS[idx];
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/phg_isqrt.sv
`default_nettype none
// ============================================================================
// phg_isqrt: bit-serial integer square root
// Restoring digit-by-digit root of a 64-bit value, one root bit per cycle.
// ============================================================================
module phg_isqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [phg_pkg::SQ_W-1:0]      radicand,
    output logic      [phg_pkg::DIST_W-1:0]    root,
    output logic                               done
);

    logic [phg_pkg::SQ_W-1:0]   src_reg;
    logic [33:0]                rem_reg;
    logic [phg_pkg::DIST_W-1:0] root_reg;
    logic [4:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [35:0]                rem_sh;
    logic [35:0]                trial;
    logic                       fits;

    assign rem_sh = {rem_reg, src_reg[phg_pkg::SQ_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);
    assign root   = root_reg;
    assign done   = done_reg;

    // Control: thirty-two steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Remainder and partial root.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            src_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            src_reg <= {src_reg[phg_pkg::SQ_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= 34'(rem_sh - trial);
                root_reg <= {root_reg[phg_pkg::DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[33:0];
                root_reg <= {root_reg[phg_pkg::DIST_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/phg_back.sv
`default_nettype none
// ============================================================================
// phg_back: guidance back end
// Runs the CORDIC and the square root side by side on a queued item, then
// applies the proportional heading update and holds the result for output.
// ============================================================================
module phg_back #(
    parameter int CORDIC_STEPS = phg_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire phg_pkg::cfg_t        cfg,
    input  wire phg_pkg::work_t       head,
    input  wire phg_pkg::q_stat_t     stat,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output phg_pkg::out_item_t        out_item
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_RUN  = 4'b0010,
        B_GAIN = 4'b0100,
        B_SEND = 4'b1000
    } back_state_t;

    back_state_t                         state_reg;
    back_state_t                         state_next;
    logic                                far_reg;
    logic                                coincident_reg;
    logic [phg_pkg::ANGLE_W-1:0]         heading_reg;
    logic [phg_pkg::ANGLE_W-1:0]         bearing_reg;
    logic [phg_pkg::DIST_W-1:0]          dist_reg;
    logic signed [32:0]                  prod_reg;
    logic                                out_valid_reg;
    phg_pkg::out_item_t                  out_item_reg;
    logic [phg_pkg::ACC_W-1:0]           angle;
    logic [phg_pkg::ACC_W-1:0]           angle_rnd;
    logic [phg_pkg::DIST_W-1:0]          root;
    logic                                cordic_done;
    logic                                sqrt_done;
    logic                                start;
    logic                                send;
    logic signed [phg_pkg::ANGLE_W-1:0]  err;
    logic signed [32:0]                  delta;
    logic [phg_pkg::ANGLE_W-1:0]         heading_w;

    assign start = (state_reg == B_IDLE) && !stat.empty;
    assign pop   = start;
    assign send  = (state_reg == B_SEND) && (!out_valid_reg || out_ready);

    phg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .dx    (head.dx),
        .dy    (head.dy),
        .angle (angle),
        .done  (cordic_done)
    );

    phg_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .radicand (head.sum_sq),
        .root     (root),
        .done     (sqrt_done)
    );

    // Bearing rounded half up to 16 bits.
    assign angle_rnd = angle + 32'h0000_8000;

    // Heading error wrapped by modulo-2^16 arithmetic, then scaled by the gain.
    assign err       = $signed(bearing_reg - heading_reg);
    assign delta     = prod_reg >>> 16;
    assign heading_w = heading_reg + delta[phg_pkg::ANGLE_W-1:0];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!stat.empty)
                begin
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (cordic_done && sqrt_done)
                begin
                    state_next = B_GAIN;
                end
            end
            B_GAIN:
            begin
                state_next = B_SEND;
            end
            B_SEND:
            begin
                if (send)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state, kept heading and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (send)
            begin
                heading_reg   <= heading_w;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            far_reg        <= head.far;
            coincident_reg <= head.coincident;
        end
        if ((state_reg == B_RUN) && cordic_done && sqrt_done)
        begin
            bearing_reg <= coincident_reg ? '0 : angle_rnd[phg_pkg::ACC_W-1 -: 16];
            dist_reg    <= far_reg ? '1 : root;
        end
        if (state_reg == B_GAIN)
        begin
            prod_reg <= $signed({1'b0, cfg.steer_gain}) * err;
        end
        if (send)
        begin
            out_item_reg.new_heading     <= heading_w;
            out_item_reg.bearing         <= bearing_reg;
            out_item_reg.commanded_speed <= dist_reg;
            out_item_reg.intercepted     <= (dist_reg < cfg.capture_radius);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

FILE: test/phg_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// phg_checker: result predictor and comparator for pursuit heading guidance
// Watches the input, output and register-write ports of the block. For every
// accepted input transaction it computes the expected bearing, distance,
// intercept flag and updated heading with its own CORDIC, square root and
// heading state. Each accepted output transaction is compared field by field
// with the oldest expected result.
// ============================================================================
module phg_checker #(
    parameter int STEPS = phg_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire phg_pkg::in_item_t             in_item,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire phg_pkg::out_item_t            out_item,
    input  wire logic                          cfg_we,
    input  wire logic [phg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [phg_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                                 error_total,
    output int                                 backlog,
    output int                                 result_total,
    output int                                 capture_total
);

    // Arctangent of 2^-k as a fraction of a full turn, scaled by 2^32.
    localparam bit [31:0] ARC_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Register values after reset: gain of about 0.1 and a radius of 3.0.
    localparam bit [15:0] GAIN_AT_RESET   = 16'd6554;
    localparam bit [31:0] RADIUS_AT_RESET = 32'd196608;

    // Largest sum of squares whose root still fits in 32 bits.
    localparam bit [64:0] ROOT_CEILING = 65'h0_FFFF_FFFE_0000_0001;

    bit [15:0] heading_now = '0;
    bit [15:0] gain_now    = GAIN_AT_RESET;
    bit [31:0] radius_now  = RADIUS_AT_RESET;
    phg_pkg::out_item_t due_results [$];

    initial
    begin
        error_total   = 0;
        backlog       = 0;
        result_total  = 0;
        capture_total = 0;
    end

    // Vectoring CORDIC. A vector in the left half plane is first turned by pi,
    // then each micro-rotation drives y toward zero with floor shifts.
    function automatic bit [15:0] cordic_bearing(input longint dx, input longint dy);
        longint    vx;
        longint    vy;
        longint    tx;
        bit [31:0] turn;
        bit [31:0] rounded;
        int        k;
        if (dx == 0 && dy == 0)
            return 16'h0000;
        vx   = dx * 64'sd16777216;
        vy   = dy * 64'sd16777216;
        turn = 32'h0;
        if (vx < 0)
        begin
            vx   = -vx;
            vy   = -vy;
            turn = 32'h8000_0000;
        end
        for (k = 0; k < STEPS && k < 32; k++)
        begin
            tx = vx;
            if (vy >= 0)
            begin
                vx   = vx + (vy >>> k);
                vy   = vy - (tx >>> k);
                turn = turn + ARC_STEP[k];
            end
            else
            begin
                vx   = vx - (vy >>> k);
                vy   = vy + (tx >>> k);
                turn = turn - ARC_STEP[k];
            end
        end
        rounded = turn + 32'h0000_8000;
        return rounded[31:16];
    endfunction

    // Exact integer square root, one result bit per pair of input bits.
    function automatic bit [31:0] floor_root(input bit [63:0] square);
        bit [63:0] rest;
        bit [63:0] root;
        bit [63:0] probe;
        rest  = square;
        root  = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > square)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[31:0];
    endfunction

    // Euclidean distance, saturated when the root no longer fits in 32 bits.
    function automatic bit [31:0] range_to_goal(input longint dx, input longint dy);
        bit [63:0] ax;
        bit [63:0] ay;
        bit [64:0] square_sum;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        square_sum = {1'b0, ax * ax} + {1'b0, ay * ay};
        if (square_sum > ROOT_CEILING)
            return 32'hFFFF_FFFF;
        return floor_root(square_sum[63:0]);
    endfunction

    // Computes the guidance result for one transaction and advances the
    // kept heading by gain times the wrapped heading error.
    function phg_pkg::out_item_t steer_update(input phg_pkg::in_item_t item);
        longint    dx;
        longint    dy;
        longint    err;
        longint    delta;
        bit [15:0] brg;
        bit [15:0] diff;
        bit [31:0] range_now;
        phg_pkg::out_item_t res;
        dx    = longint'($signed(item.goal_x)) - longint'($signed(item.chaser_x));
        dy    = longint'($signed(item.goal_y)) - longint'($signed(item.chaser_y));
        brg   = cordic_bearing(dx, dy);
        range_now = range_to_goal(dx, dy);
        diff  = brg - heading_now;
        err   = longint'($signed(diff));
        delta = (longint'(gain_now) * err) >>> 16;
        heading_now = heading_now + delta[15:0];
        res.new_heading     = heading_now;
        res.bearing         = brg;
        res.commanded_speed = range_now;
        res.intercepted     = (range_now < radius_now);
        return res;
    endfunction

    // Track register writes, compare results and queue new predictions.
    always @(posedge clk or negedge rst_n)
    begin
        phg_pkg::out_item_t want;
        phg_pkg::out_item_t fresh;
        if (!rst_n)
        begin
            heading_now = '0;
            gain_now    = GAIN_AT_RESET;
            radius_now  = RADIUS_AT_RESET;
            due_results.delete();
            backlog = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    phg_pkg::REG_STEER_GAIN:     gain_now   = cfg_data[15:0];
                    phg_pkg::REG_CAPTURE_RADIUS: radius_now = cfg_data;
                    default:                     ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                result_total++;
                if (due_results.size() == 0)
                begin
                    $error("result transaction with no input waiting for it");
                    error_total++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_item.new_heading !== want.new_heading)
                    begin
                        $error("new_heading: expected %0d, got %0d",
                               want.new_heading, out_item.new_heading);
                        error_total++;
                    end
                    if (out_item.bearing !== want.bearing)
                    begin
                        $error("bearing: expected %0d, got %0d",
                               want.bearing, out_item.bearing);
                        error_total++;
                    end
                    if (out_item.commanded_speed !== want.commanded_speed)
                    begin
                        $error("commanded_speed: expected %0d, got %0d",
                               want.commanded_speed, out_item.commanded_speed);
                        error_total++;
                    end
                    if (out_item.intercepted !== want.intercepted)
                    begin
                        $error("intercepted: expected %0d, got %0d",
                               want.intercepted, out_item.intercepted);
                        error_total++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                fresh = steer_update(in_item);
                if (fresh.intercepted)
                    capture_total++;
                due_results.push_back(fresh);
            end
            backlog = due_results.size();
        end
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: stimulus and verdict for pursuit heading guidance
// Drives a directed set of geometric corner cases, then random chaser and
// target positions under several gain and radius settings, with bursty input
// and a stalling output side. The checker predicts and compares every result.
// ============================================================================
module testbench;

    localparam int STEPS       = phg_pkg::CORDIC_STEPS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;

    // Register indexes that the block must ignore.
    localparam logic [phg_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [phg_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // Coordinate extremes and one unit in Q16.16.
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam int                 UNIT      = 65536;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    phg_pkg::in_item_t              in_item   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    phg_pkg::out_item_t             out_item;
    logic                           cfg_we    = 1'b0;
    logic [phg_pkg::CFG_IDX_W-1:0]  cfg_index = phg_pkg::REG_STEER_GAIN;
    logic [phg_pkg::CFG_DAT_W-1:0]  cfg_data  = '0;

    int        error_total;
    int        backlog;
    int        result_total;
    int        capture_total;
    int        cycle_count   = 0;
    int        burst_left    = 0;
    int        sent_total    = 0;
    int        setting_total = 1;
    int        sink_mode     = 0;
    int        sink_left     = 0;
    bit [31:0] cur_radius    = 32'd196608;

    pursuit_heading_guidance #(
        .CORDIC_STEPS (STEPS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    phg_checker #(
        .STEPS (STEPS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_total   (error_total),
        .backlog       (backlog),
        .result_total  (result_total),
        .capture_total (capture_total)
    );

    // 100 MHz clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // The result side switches between steady acceptance, random stalls,
    // mostly-stalled stretches and a periodic pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sink_left == 0)
            begin
                sink_mode <= $urandom_range(0, 3);
                sink_left <= $urandom_range(20, 300);
            end
            else
            begin
                sink_left <= sink_left - 1;
            end
            case (sink_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (sink_left % 8 < 5);
            endcase
        end
    end

    function automatic phg_pkg::in_item_t pos(input logic signed [31:0] cx,
                                              input logic signed [31:0] cy,
                                              input logic signed [31:0] gx,
                                              input logic signed [31:0] gy);
        phg_pkg::in_item_t item;
        item.chaser_x = cx;
        item.chaser_y = cy;
        item.goal_x   = gx;
        item.goal_y   = gy;
        return item;
    endfunction

    // A coordinate at or close to the ends of the range.
    function automatic logic [31:0] extreme_coord();
        case ($urandom_range(0, 6))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return COORD_MIN + $urandom_range(0, 255);
            3:       return COORD_MAX - $urandom_range(0, 255);
            4:       return 32'h0000_0000;
            5:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Random positions: raw bit patterns, close encounters scaled to the
    // capture radius, axis-aligned targets, distances right at the radius,
    // extreme coordinates and moderate separations.
    function automatic phg_pkg::in_item_t random_geometry();
        longint    cx;
        longint    cy;
        longint    gx;
        longint    gy;
        longint    span;
        longint    mag;
        longint    room;
        longint    swap;
        int        pick;
        pick = $urandom_range(0, 99);
        cx = 0;
        cy = 0;
        gx = 0;
        gy = 0;
        if (pick < 20)
        begin
            return pos($urandom(), $urandom(), $urandom(), $urandom());
        end
        else if (pick < 45)
        begin
            span = (cur_radius > 32'h0010_0000) ? 64'sd1048576 : longint'(cur_radius);
            span = span + 16;
            cx = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824;
            cy = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824;
            gx = cx + longint'($urandom_range(0, 4 * span)) - 2 * span;
            gy = cy + longint'($urandom_range(0, 4 * span)) - 2 * span;
        end
        else if (pick < 55)
        begin
            mag = longint'($urandom_range(1, 32'h1000_0000));
            if ($urandom_range(0, 1))
                mag = -mag;
            cx = longint'($urandom_range(0, 32'h3FFF_FFFF)) - 64'sd536870912;
            cy = longint'($urandom_range(0, 32'h3FFF_FFFF)) - 64'sd536870912;
            gx = cx;
            gy = cy;
            if ($urandom_range(0, 1))
                gx = cx + mag;
            else
                gy = cy + mag;
        end
        else if (pick < 65)
        begin
            // Separation of radius - 1, radius or radius + 1 along one axis.
            mag = longint'(cur_radius) + longint'($urandom_range(0, 2)) - 1;
            if (mag < 0)
                mag = 0;
            if (mag > 64'sd4294967295)
                mag = 64'sd4294967295;
            room = 64'sd4294967295 - mag;
            cx = longint'($urandom_range(0, room[31:0])) - 64'sd2147483648;
            gx = cx + mag;
            cy = longint'($signed($urandom()));
            gy = cy;
            if ($urandom_range(0, 1))
            begin
                swap = cx;
                cx   = gx;
                gx   = swap;
            end
            if ($urandom_range(0, 1))
            begin
                swap = cx;
                cx   = cy;
                cy   = swap;
                swap = gx;
                gx   = gy;
                gy   = swap;
            end
        end
        else if (pick < 75)
        begin
            return pos(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
        end
        else
        begin
            cx = longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sd16777216;
            cy = longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sd16777216;
            gx = longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sd16777216;
            gy = longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sd16777216;
        end
        return pos(cx[31:0], cy[31:0], gx[31:0], gy[31:0]);
    endfunction

    // Presents one input transaction and returns once it is accepted. Between
    // bursts of random length the sender may pause for a random gap.
    task automatic feed(input phg_pkg::in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(20, 70);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_item  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_total++;
    endtask

    // Drops valid and waits until every expected result has been delivered.
    task automatic drain(input int settle);
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Writes both registers, then a junk write to an unused index.
    task automatic program_regs(input bit [15:0] gain, input bit [31:0] radius);
        bit [15:0] junk;
        junk = $urandom();
        cfg_we    <= 1'b1;
        cfg_index <= phg_pkg::REG_STEER_GAIN;
        cfg_data  <= {junk, gain};
        @(posedge clk);
        cfg_index <= phg_pkg::REG_CAPTURE_RADIUS;
        cfg_data  <= radius;
        @(posedge clk);
        cfg_index <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
        cfg_data  <= $urandom();
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_index <= phg_pkg::REG_STEER_GAIN;
        cfg_data  <= '0;
        @(posedge clk);
        cur_radius = radius;
        setting_total++;
    endtask

    task automatic random_run(input int count);
        int n;
        for (n = 0; n < count; n++)
            feed(random_geometry());
    endtask

    // Main sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases under the reset register values.
        feed(pos(0, 0, 0, 0));
        feed(pos(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0));
        feed(pos(UNIT, 5, -3 * UNIT, 5));
        feed(pos(0, 0, 10 * UNIT, 0));
        feed(pos(0, 0, 0, 10 * UNIT));
        feed(pos(0, 0, 0, -10 * UNIT));
        feed(pos(0, 0, 5 * UNIT, 5 * UNIT));
        feed(pos(0, 0, -5 * UNIT, 5 * UNIT));
        feed(pos(0, 0, -5 * UNIT, -5 * UNIT));
        feed(pos(0, 0, 5 * UNIT, -5 * UNIT));
        feed(pos(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        feed(pos(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
        // Largest separation whose root still fits, then one just past it.
        feed(pos(COORD_MIN, 0, COORD_MAX, 0));
        feed(pos(COORD_MIN, 0, COORD_MAX, 1));
        // Just inside and exactly on the capture radius.
        feed(pos(0, 0, 196607, 0));
        feed(pos(0, 0, 196608, 0));
        feed(pos(0, 0, 0, -196607));
        feed(pos(-1, -1, 0, 0));
        feed(pos(0, 0, 1, 0));
        feed(pos(0, 0, -1, 0));
        feed(pos(COORD_MAX, 0, COORD_MIN, 0));
        feed(pos(0, 0, -1, 1));
        feed(pos(0, 0, -1, -1));
        drain(8);

        // Random phases over several register settings, extremes included.
        program_regs(16'd0, 32'd0);
        random_run(260);
        drain(8);
        program_regs(16'hFFFF, 32'hFFFF_FFFF);
        random_run(320);
        drain(8);
        program_regs(16'd6554, 32'd196608);
        random_run(320);
        drain(8);
        program_regs($urandom_range(0, 65535), $urandom_range(0, 32'h00FF_FFFF));
        random_run(380);
        drain(8);
        program_regs(16'd1, 32'd1);
        random_run(220);
        drain(8);
        program_regs($urandom_range(0, 65535), $urandom());
        random_run(380);
        drain(60);

        $display("Sent %0d transactions across %0d gain and radius settings.",
                 sent_total, setting_total);
        $display("Compared %0d results, %0d of them flagged as intercepts.",
                 result_total, capture_total);
        if (error_total == 0 && backlog == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: pursuit_heading_guidance.f
rtl/phg_pkg.sv
rtl/phg_queue.sv
rtl/phg_front.sv
rtl/phg_cordic.sv
rtl/phg_isqrt.sv
rtl/phg_back.sv
rtl/pursuit_heading_guidance.sv
test/phg_checker.sv
test/testbench.sv
